// ----- rtl/ssf_pkg.sv -----
// Shared types and constants of the scanline seed fill block.
// Used by ssf_frame_mem and the top level; depends on nothing else.
`default_nettype none
package ssf_pkg;

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_WRITE = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_FILL  = 2'd2;
	// Reserved code: no effect, reported as nothing done.
	localparam logic [1:0] OP_RSVD  = 2'd3;

	// Result status codes.
	localparam logic [1:0] STS_DONE = 2'd0;
	localparam logic [1:0] STS_NONE = 2'd1;
	localparam logic [1:0] STS_OVF  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_CANVAS_WIDTH  = 1'b0;
	localparam logic REG_CANVAS_HEIGHT = 1'b1;

	localparam int CFG_W   = 9;
	localparam int IN_DW   = 48;
	localparam int OUT_DW  = 32;
	localparam int FIELD_CW = 24;

	// Write enables of the frame store.
	typedef struct packed {
		logic color;
		logic flag;
	} fm_we_t;

	typedef enum logic [4:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_READ_WAIT,
		ST_SEED_CHK,
		ST_POP,
		ST_POP_WAIT,
		ST_LREQ,
		ST_LCHK,
		ST_RREQ,
		ST_RCHK,
		ST_PAINT,
		ST_NB_START,
		ST_FREQ,
		ST_FCHK,
		ST_SREQ,
		ST_SCHK
	} state_t;

endpackage
`default_nettype wire

// ----- rtl/ssf_frame_mem.sv -----
// Frame store: pixel colors and set flags, one address port, registered read.
// Depends on ssf_pkg for the write enable struct.
`default_nettype none
module ssf_frame_mem #(
	parameter int AW = 16,
	parameter int CW = 24
) (
	input  wire logic            clk,
	input  wire logic [AW-1:0]   addr,
	input  wire ssf_pkg::fm_we_t we,
	input  wire logic [CW-1:0]   wcolor,
	input  wire logic            wflag,
	output logic      [CW-1:0]   rcolor,
	output logic                 rflag
);

	logic [CW-1:0] color_mem [2**AW];
	logic          flag_mem  [2**AW];

	always_ff @(posedge clk) begin
		if (we.color) begin
			color_mem[addr] <= wcolor;
		end
		rcolor <= color_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (we.flag) begin
			flag_mem[addr] <= wflag;
		end
		rflag <= flag_mem[addr];
	end

endmodule
`default_nettype wire

// ----- rtl/ssf_stack_mem.sv -----
// Span seed stack storage, one address port with registered read.
// Stand-alone; no package use.
`default_nettype none
module ssf_stack_mem #(
	parameter int DW    = 16,
	parameter int DEPTH = 1024,
	parameter int SPW   = 10
) (
	input  wire logic           clk,
	input  wire logic [SPW-1:0] addr,
	input  wire logic           we,
	input  wire logic [DW-1:0]  wdata,
	output logic      [DW-1:0]  rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule
`default_nettype wire

// ----- rtl/scanline_seed_fill_top.sv -----
// Top level of the scanline seed fill block: sequencer, probe compare and outputs.
// Depends on ssf_pkg, ssf_frame_mem and ssf_stack_mem.
//
// Usage: items arrive on the s_axis channel; tuser carries the operation
// (write pixel, read pixel, seed fill) and tdata the coordinates, color and
// set flag. Every item produces exactly one result transfer on m_axis with
// the read color, the read set flag and a status code. Canvas width and
// height are written through the cfg port while the block is idle.
// During a fill every probe goes through the single frame store port, which
// reads one pixel per cycle with a registered output; one shared compare unit
// matches the probed pixel against the original seed color.
// After reset the set flags are swept to zero, one address a cycle, over all
// 2**AW addresses of the store (65536 at the defaults); tready stays low
// meanwhile, while configuration writes are still taken.
// The result waits in an output register; while the receiver stalls it,
// no new input item is accepted.
`default_nettype none
module scanline_seed_fill_top #(
	parameter int MAX_WIDTH   = 256,
	parameter int MAX_HEIGHT  = 256,
	parameter int COLOR_BITS  = 24,
	parameter int STACK_DEPTH = 1024
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	// x[7:0], y[15:8], color[39:16], set_flag[40], zero fill above
	input  wire logic [ssf_pkg::IN_DW-1:0]   s_axis_tdata,
	// operation[1:0]
	input  wire logic [1:0]                  s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	// read_color[23:0], read_set[24], status[26:25], zero fill above
	output logic      [ssf_pkg::OUT_DW-1:0]  m_axis_tdata,
	input  wire logic                        cfg_we,
	input  wire logic                        cfg_index,
	input  wire logic [ssf_pkg::CFG_W-1:0]   cfg_data
);

	localparam int XW   = $clog2(MAX_WIDTH);
	localparam int YW   = $clog2(MAX_HEIGHT);
	localparam int AW   = XW + YW;
	localparam int SXW  = XW + 2;
	localparam int SYW  = YW + 2;
	localparam int CNTW = $clog2(STACK_DEPTH + 1);
	localparam int SPW  = $clog2(STACK_DEPTH);

	ssf_pkg::state_t state_q, state_d;

	// Configuration.
	logic [ssf_pkg::CFG_W-1:0] cw_q, ch_q;
	logic [XW:0]               ew;
	logic [YW:0]               eh;
	logic signed [SXW-1:0]     ew_s;
	logic signed [SYW-1:0]     eh_s;

	// Latched input item.
	logic [1:0]            op_q;
	logic [7:0]            x_q, y_q;
	logic [COLOR_BITS-1:0] col_q;
	logic                  flag_q;
	logic                  in_canvas;

	// Fill datapath.
	logic [AW-1:0]         clr_q;
	logic [CNTW-1:0]       cnt_q;
	logic [COLOR_BITS-1:0] orig_q;
	logic [XW-1:0]         cx_q;
	logic [YW-1:0]         cy_q, ny_q;
	logic signed [SXW-1:0] scan_q, left_q, right_q;
	logic                  dir_q;
	logic signed [SYW-1:0] ny_cand;
	logic                  ny_ok;
	logic                  match;
	logic                  seed_ok;
	logic [XW-1:0]         sx;
	logic [YW-1:0]         sy;

	// Memory ports.
	logic [AW-1:0]         fm_addr;
	ssf_pkg::fm_we_t       fm_we;
	logic [COLOR_BITS-1:0] fm_wcolor, fm_rcolor;
	logic                  fm_wflag, fm_rflag;
	logic [SPW-1:0]        st_addr;
	logic                  st_we;
	logic [AW-1:0]         st_wdata, st_rdata;

	// Result.
	logic        fin;
	logic [1:0]  fin_status;
	logic        fin_rs;
	logic [23:0] fin_rc;
	logic [31:0] rc32;
	logic        out_valid_q;
	logic [23:0] out_rc_q;
	logic        out_rs_q;
	logic [1:0]  out_status_q;
	logic        in_fire;

	ssf_frame_mem #(.AW(AW), .CW(COLOR_BITS)) u_frame (
		.clk    (clk),
		.addr   (fm_addr),
		.we     (fm_we),
		.wcolor (fm_wcolor),
		.wflag  (fm_wflag),
		.rcolor (fm_rcolor),
		.rflag  (fm_rflag)
	);

	ssf_stack_mem #(.DW(AW), .DEPTH(STACK_DEPTH), .SPW(SPW)) u_stack (
		.clk   (clk),
		.addr  (st_addr),
		.we    (st_we),
		.wdata (st_wdata),
		.rdata (st_rdata)
	);

	// The effective canvas is the smaller of the register and the store size.
	always_comb begin
		ew = (int'(cw_q) > MAX_WIDTH) ? (XW+1)'(MAX_WIDTH) : (XW+1)'(cw_q);
		eh = (int'(ch_q) > MAX_HEIGHT) ? (YW+1)'(MAX_HEIGHT) : (YW+1)'(ch_q);
		ew_s = signed'({1'b0, ew});
		eh_s = signed'({1'b0, eh});
	end

	assign in_canvas = (32'(x_q) < 32'(ew)) && (32'(y_q) < 32'(eh));
	assign sx      = XW'(32'(x_q));
	assign sy      = YW'(32'(y_q));
	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ssf_pkg::ST_IDLE) && !out_valid_q;

	// The shared compare unit: a probed pixel belongs to the region when it
	// is set and still holds the original seed color.
	assign match   = fm_rflag && (fm_rcolor == orig_q);
	assign seed_ok = fm_rflag && (fm_rcolor != col_q);

	assign ny_cand = dir_q ? (signed'(SYW'(cy_q)) + SYW'(1)) : (signed'(SYW'(cy_q)) - SYW'(1));
	assign ny_ok   = !ny_cand[SYW-1] && (ny_cand < eh_s);
	assign rc32    = 32'(fm_rcolor);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ssf_pkg::ST_CLEAR: begin
				if (clr_q == '1) state_d = ssf_pkg::ST_IDLE;
			end
			ssf_pkg::ST_IDLE: begin
				if (in_fire) state_d = ssf_pkg::ST_EXEC;
			end
			ssf_pkg::ST_EXEC: begin
				if (in_canvas && op_q == ssf_pkg::OP_READ) state_d = ssf_pkg::ST_READ_WAIT;
				else if (in_canvas && op_q == ssf_pkg::OP_FILL) state_d = ssf_pkg::ST_SEED_CHK;
				else state_d = ssf_pkg::ST_IDLE;
			end
			ssf_pkg::ST_READ_WAIT: state_d = ssf_pkg::ST_IDLE;
			ssf_pkg::ST_SEED_CHK: begin
				state_d = seed_ok ? ssf_pkg::ST_POP : ssf_pkg::ST_IDLE;
			end
			ssf_pkg::ST_POP: begin
				state_d = (cnt_q == '0) ? ssf_pkg::ST_IDLE : ssf_pkg::ST_POP_WAIT;
			end
			ssf_pkg::ST_POP_WAIT: state_d = ssf_pkg::ST_LREQ;
			ssf_pkg::ST_LREQ: begin
				state_d = scan_q[SXW-1] ? ssf_pkg::ST_RREQ : ssf_pkg::ST_LCHK;
			end
			ssf_pkg::ST_LCHK: begin
				state_d = match ? ssf_pkg::ST_LREQ : ssf_pkg::ST_RREQ;
			end
			ssf_pkg::ST_RREQ: begin
				state_d = (scan_q >= ew_s) ? ssf_pkg::ST_PAINT : ssf_pkg::ST_RCHK;
			end
			ssf_pkg::ST_RCHK: begin
				state_d = match ? ssf_pkg::ST_RREQ : ssf_pkg::ST_PAINT;
			end
			ssf_pkg::ST_PAINT: begin
				if (scan_q > right_q) state_d = ssf_pkg::ST_NB_START;
			end
			ssf_pkg::ST_NB_START: begin
				if (ny_ok) state_d = ssf_pkg::ST_FREQ;
				else if (dir_q) state_d = ssf_pkg::ST_POP;
			end
			ssf_pkg::ST_FREQ: begin
				if (scan_q > right_q) begin
					state_d = dir_q ? ssf_pkg::ST_POP : ssf_pkg::ST_NB_START;
				end else begin
					state_d = ssf_pkg::ST_FCHK;
				end
			end
			ssf_pkg::ST_FCHK: begin
				if (!match) state_d = ssf_pkg::ST_FREQ;
				else if (32'(cnt_q) >= STACK_DEPTH) state_d = ssf_pkg::ST_IDLE;
				else state_d = ssf_pkg::ST_SREQ;
			end
			ssf_pkg::ST_SREQ: begin
				if (scan_q > right_q) begin
					state_d = dir_q ? ssf_pkg::ST_POP : ssf_pkg::ST_NB_START;
				end else begin
					state_d = ssf_pkg::ST_SCHK;
				end
			end
			ssf_pkg::ST_SCHK: begin
				state_d = match ? ssf_pkg::ST_SREQ : ssf_pkg::ST_FREQ;
			end
			default: state_d = ssf_pkg::ST_IDLE;
		endcase
	end

	// Memory controls and result.
	always_comb begin
		fm_addr    = {cy_q, scan_q[XW-1:0]};
		fm_we      = '0;
		fm_wcolor  = col_q;
		fm_wflag   = 1'b1;
		st_addr    = cnt_q[SPW-1:0];
		st_we      = 1'b0;
		st_wdata   = {ny_q, scan_q[XW-1:0]};
		fin        = 1'b0;
		fin_status = ssf_pkg::STS_DONE;
		fin_rs     = 1'b0;
		fin_rc     = '0;
		case (state_q)
			ssf_pkg::ST_CLEAR: begin
				fm_addr  = clr_q;
				fm_we    = '{color: 1'b0, flag: 1'b1};
				fm_wflag = 1'b0;
			end
			ssf_pkg::ST_EXEC: begin
				fm_addr = {sy, sx};
				if (op_q == ssf_pkg::OP_WRITE && in_canvas) begin
					fm_we    = '{color: 1'b1, flag: 1'b1};
					fm_wflag = flag_q;
				end
				if (!in_canvas || (op_q != ssf_pkg::OP_READ && op_q != ssf_pkg::OP_FILL)) begin
					fin        = 1'b1;
					fin_status = (in_canvas && op_q == ssf_pkg::OP_WRITE) ?
						ssf_pkg::STS_DONE : ssf_pkg::STS_NONE;
				end
			end
			ssf_pkg::ST_READ_WAIT: begin
				fin    = 1'b1;
				fin_rs = fm_rflag;
				fin_rc = fm_rflag ? rc32[23:0] : '0;
			end
			ssf_pkg::ST_SEED_CHK: begin
				st_addr  = '0;
				st_we    = seed_ok;
				st_wdata = {sy, sx};
				if (!seed_ok) begin
					fin        = 1'b1;
					fin_status = ssf_pkg::STS_NONE;
				end
			end
			ssf_pkg::ST_POP: begin
				st_addr = SPW'(cnt_q - CNTW'(1));
				fin     = (cnt_q == '0);
			end
			ssf_pkg::ST_PAINT: begin
				fm_we = '{color: 1'b1, flag: 1'b1};
				if (scan_q > right_q) fm_we = '0;
			end
			ssf_pkg::ST_FREQ, ssf_pkg::ST_SREQ: begin
				fm_addr = {ny_q, scan_q[XW-1:0]};
			end
			ssf_pkg::ST_FCHK: begin
				if (match && 32'(cnt_q) >= STACK_DEPTH) begin
					fin        = 1'b1;
					fin_status = ssf_pkg::STS_OVF;
				end else if (match) begin
					st_we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ssf_pkg::ST_CLEAR;
			clr_q       <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			cw_q        <= ssf_pkg::CFG_W'(256);
			ch_q        <= ssf_pkg::CFG_W'(256);
		end else begin
			state_q <= state_d;
			if (state_q == ssf_pkg::ST_CLEAR) clr_q <= clr_q + AW'(1);
			if (cfg_we) begin
				if (cfg_index == ssf_pkg::REG_CANVAS_WIDTH) cw_q <= cfg_data;
				else ch_q <= cfg_data;
			end
			if (fin) out_valid_q <= 1'b1;
			else if (m_axis_tready) out_valid_q <= 1'b0;
			if (state_q == ssf_pkg::ST_SEED_CHK && seed_ok) cnt_q <= CNTW'(1);
			else if (state_q == ssf_pkg::ST_POP && cnt_q != '0) cnt_q <= cnt_q - CNTW'(1);
			else if (state_q == ssf_pkg::ST_FCHK && match) begin
				if (32'(cnt_q) >= STACK_DEPTH) cnt_q <= '0;
				else cnt_q <= cnt_q + CNTW'(1);
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_q   <= s_axis_tuser;
			x_q    <= s_axis_tdata[7:0];
			y_q    <= s_axis_tdata[15:8];
			col_q  <= COLOR_BITS'({8'd0, s_axis_tdata[39:16]});
			flag_q <= s_axis_tdata[40];
		end
		if (fin) begin
			out_rc_q     <= fin_rc;
			out_rs_q     <= fin_rs;
			out_status_q <= fin_status;
		end
		case (state_q)
			ssf_pkg::ST_SEED_CHK: orig_q <= fm_rcolor;
			ssf_pkg::ST_POP_WAIT: begin
				cx_q   <= st_rdata[XW-1:0];
				cy_q   <= st_rdata[AW-1:XW];
				scan_q <= signed'(SXW'(st_rdata[XW-1:0]));
			end
			ssf_pkg::ST_LREQ: begin
				if (scan_q[SXW-1]) begin
					left_q <= scan_q + SXW'(1);
					scan_q <= signed'(SXW'(cx_q));
				end
			end
			ssf_pkg::ST_LCHK: begin
				if (match) begin
					scan_q <= scan_q - SXW'(1);
				end else begin
					left_q <= scan_q + SXW'(1);
					scan_q <= signed'(SXW'(cx_q));
				end
			end
			ssf_pkg::ST_RREQ: begin
				if (scan_q >= ew_s) begin
					right_q <= scan_q - SXW'(1);
					scan_q  <= left_q;
					dir_q   <= 1'b0;
				end
			end
			ssf_pkg::ST_RCHK: begin
				if (match) begin
					scan_q <= scan_q + SXW'(1);
				end else begin
					right_q <= scan_q - SXW'(1);
					scan_q  <= left_q;
					dir_q   <= 1'b0;
				end
			end
			ssf_pkg::ST_PAINT: begin
				if (scan_q <= right_q) scan_q <= scan_q + SXW'(1);
			end
			ssf_pkg::ST_NB_START: begin
				if (ny_ok) begin
					ny_q   <= YW'(ny_cand);
					scan_q <= left_q;
				end else begin
					dir_q <= 1'b1;
				end
			end
			ssf_pkg::ST_FREQ, ssf_pkg::ST_SREQ: begin
				if (scan_q > right_q) dir_q <= 1'b1;
			end
			ssf_pkg::ST_FCHK: begin
				if (!match) scan_q <= scan_q + SXW'(1);
			end
			ssf_pkg::ST_SCHK: begin
				if (match) scan_q <= scan_q + SXW'(1);
			end
			default: begin
			end
		endcase
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_status_q, out_rs_q, out_rc_q};

`ifndef SYNTHESIS
	// The stack never holds more seeds than it has room for.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(cnt_q) <= STACK_DEPTH)
		else $error("seed stack count beyond depth");

	// Every fill leaves the stack empty once the block is idle again.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ssf_pkg::ST_IDLE |-> cnt_q == '0)
		else $error("seed stack not empty while idle");

	// A result is produced only as the sequencer returns to idle.
	a_fin_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fin |=> state_q == ssf_pkg::ST_IDLE && out_valid_q)
		else $error("result without return to idle");

	// Painting stays inside the canvas columns.
	a_paint_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		fm_we.color && state_q == ssf_pkg::ST_PAINT |-> !scan_q[SXW-1] && scan_q < ew_s)
		else $error("paint outside the canvas");
`endif

endmodule
`default_nettype wire
